// ===== src/bmu_pkg.sv =====
// ----------------------------------------------------------------------------
// bmu_pkg: shared constants and types of the bilinear map upscaler
// Map geometry, banking of the map store and field widths.
// ----------------------------------------------------------------------------
package bmu_pkg;

    localparam int MAP_SIDE   = 320;

    // Field widths
    localparam int COORD_W    = 14;
    localparam int VAL_W      = 16;
    localparam int SCALE_W    = 25;
    localparam int FRAC_W     = 16;

    // Map indexing; the store is split into four banks by row and column parity
    localparam int IDX_W      = $clog2(MAP_SIDE);
    localparam int HALF_SIDE  = (MAP_SIDE + 1) / 2;
    localparam int BANK_DEPTH = HALF_SIDE * HALF_SIDE;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int NUM_BANKS  = 4;

    // Twice the pixel centre, (2c+1)*scale, Q24.16
    localparam int T_W        = COORD_W + 1 + SCALE_W;
    localparam int SRC_W      = T_W - 1;
    localparam int IP_W       = SRC_W - FRAC_W;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    // Transaction operation codes
    typedef enum logic {OP_WRITE = 1'b0, OP_QUERY = 1'b1} t_map_op;

    // Neighbour indexes and fraction of one axis
    typedef struct packed {
        logic [IDX_W-1:0]  i0;
        logic [IDX_W-1:0]  i1;
        logic [FRAC_W-1:0] f;
    } t_axis;

    // Bank selection carried from the address stage to the blend stage
    typedef struct packed {
        logic x0_odd;
        logic x1_odd;
        logic y0_odd;
        logic y1_odd;
    } t_bank_sel;

endpackage

// ===== src/bmu_ram.sv =====
// ----------------------------------------------------------------------------
// bmu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bilinear_map_upscaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_map_upscaler: bilinear resampling of a stored probability map
// Holds a square Q0.16 map, loads it entry by entry and answers pixel queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken at each rising edge with start high
//   and busy low. busy stays low, so one transaction can enter every cycle.
//   i_op = 0 writes i_value into the map at (i_row, i_col); writes outside
//   the map are dropped. i_op = 1 queries output pixel (i_col, i_row).
//   Result channel: each query gives one o_prob, shown for exactly one cycle
//   with o_valid high once the query leaves the last stage. Writes give no result.
//   Throughput is one transaction per cycle: six register stages (capture,
//   scale multiply, coordinate map, bank address and read, horizontal blend,
//   vertical blend) and four map banks split by row and column parity, so
//   the four neighbours are read in the same cycle, one per bank read port.
//   Writes and queries access the banks in the same stage, so a query sees
//   every earlier write.
//   Configuration: i_cfg_we writes i_cfg_data into scale_x (index 0) or
//   scale_y (index 1); write only while no query is in flight.
//   Reset (i_rst_n low, synchronous) empties the pipeline and sets both
//   scales to 1.0. The map is not cleared: query only written entries.
//   The receiver cannot stall; every result must be taken when shown.
// ----------------------------------------------------------------------------
module bilinear_map_upscaler
    import bmu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic [COORD_W-1:0]   i_col,
    input  logic [COORD_W-1:0]   i_row,
    input  logic [VAL_W-1:0]     i_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    output logic                 o_valid,
    output logic [VAL_W-1:0]     o_prob
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic t_axis map_axis(input logic [T_W-1:0] t);
        logic [SRC_W-1:0] src;
        logic [IP_W-1:0]  ip;
        t_axis            a;
        src = (t >= T_W'(65536)) ? SRC_W'((t - T_W'(65536)) >> 1) : '0;
        ip  = src[SRC_W-1:FRAC_W];
        if (ip > IP_W'(MAP_SIDE - 1)) begin
            a.i0 = IDX_W'(MAP_SIDE - 1);
        end else begin
            a.i0 = ip[IDX_W-1:0];
        end
        a.i1 = (a.i0 == IDX_W'(MAP_SIDE - 1)) ? a.i0 : a.i0 + 1'b1;
        a.f  = src[FRAC_W-1:0];
        return a;
    endfunction

    // a + floor(f*(b-a)/65536)
    function automatic logic signed [VAL_W+1:0] lerp(
        input logic signed [VAL_W+1:0] a,
        input logic signed [VAL_W+1:0] b,
        input logic [FRAC_W-1:0]       f
    );
        logic signed [VAL_W+2:0]              d;
        logic signed [VAL_W+FRAC_W+3:0]       p;
        d = (VAL_W+3)'(b) - (VAL_W+3)'(a);
        p = d * $signed({1'b0, f});
        return a + (VAL_W+2)'(p >>> FRAC_W);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0] r_scale_x;
    logic [SCALE_W-1:0] r_scale_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE_X: r_scale_x <= i_cfg_data;
                REG_SCALE_Y: r_scale_y <= i_cfg_data;
            endcase
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Pipeline valid bits
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_q, r_s3_wr, r_s4_q, r_s5_q, r_s6_q;
    logic r_s1_op, r_s2_op;

    logic n_s3_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_q  <= 1'b0;
            r_s3_wr <= 1'b0;
            r_s4_q  <= 1'b0;
            r_s5_q  <= 1'b0;
            r_s6_q  <= 1'b0;
        end else begin
            r_s1_v  <= start & ~busy;
            r_s2_v  <= r_s1_v;
            r_s3_q  <= r_s2_v & (r_s2_op == OP_QUERY);
            r_s3_wr <= n_s3_wr;
            r_s4_q  <= r_s3_q;
            r_s5_q  <= r_s4_q;
            r_s6_q  <= r_s5_q;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the transaction
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_s1_col, r_s1_row;
    logic [VAL_W-1:0]   r_s1_val;

    always_ff @(posedge i_clk) begin
        r_s1_op  <= i_op;
        r_s1_col <= i_col;
        r_s1_row <= i_row;
        r_s1_val <= i_value;
    end

    // ------------------------------------------------------------------
    // Stage 2: twice the pixel centre, (2c+1)*scale
    // ------------------------------------------------------------------
    logic [T_W-1:0]     n_tx, n_ty, r_s2_tx, r_s2_ty;
    logic [COORD_W-1:0] r_s2_col, r_s2_row;
    logic [VAL_W-1:0]   r_s2_val;

    assign n_tx = T_W'({r_s1_col, 1'b1}) * T_W'(r_scale_x);
    assign n_ty = T_W'({r_s1_row, 1'b1}) * T_W'(r_scale_y);

    always_ff @(posedge i_clk) begin
        r_s2_op  <= r_s1_op;
        r_s2_tx  <= n_tx;
        r_s2_ty  <= n_ty;
        r_s2_col <= r_s1_col;
        r_s2_row <= r_s1_row;
        r_s2_val <= r_s1_val;
    end

    // ------------------------------------------------------------------
    // Stage 3: map coordinates, neighbour clamp; write address check
    // ------------------------------------------------------------------
    t_axis            n_ax, n_ay;
    t_axis            r_s3_ax, r_s3_ay;
    logic [VAL_W-1:0] r_s3_val;

    always_comb begin
        n_ax = map_axis(r_s2_tx);
        n_ay = map_axis(r_s2_ty);
        // a write uses its own indexes, both neighbours on the entry itself
        if (r_s2_op == OP_WRITE) begin
            n_ax.i0 = r_s2_col[IDX_W-1:0];
            n_ax.i1 = r_s2_col[IDX_W-1:0];
            n_ay.i0 = r_s2_row[IDX_W-1:0];
            n_ay.i1 = r_s2_row[IDX_W-1:0];
        end
    end

    assign n_s3_wr = r_s2_v & (r_s2_op == OP_WRITE)
                     & (r_s2_col < COORD_W'(MAP_SIDE))
                     & (r_s2_row < COORD_W'(MAP_SIDE));

    always_ff @(posedge i_clk) begin
        r_s3_ax  <= n_ax;
        r_s3_ay  <= n_ay;
        r_s3_val <= r_s2_val;
    end

    // ------------------------------------------------------------------
    // Stage 4: bank addresses, map read or write
    // ------------------------------------------------------------------
    logic [NUM_BANKS-1:0] bank_we;
    logic [BANK_AW-1:0]   bank_addr  [NUM_BANKS];
    logic [VAL_W-1:0]     bank_rdata [NUM_BANKS];

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);

        logic [IDX_W-1:0] xb, yb;

        // pick the neighbour whose parity matches this bank
        assign xb = (r_s3_ax.i0[0] == BSEL[0]) ? r_s3_ax.i0 : r_s3_ax.i1;
        assign yb = (r_s3_ay.i0[0] == BSEL[1]) ? r_s3_ay.i0 : r_s3_ay.i1;

        assign bank_addr[b] = BANK_AW'(BANK_AW'(yb[IDX_W-1:1]) * BANK_AW'(HALF_SIDE))
                              + BANK_AW'(xb[IDX_W-1:1]);
        assign bank_we[b]   = r_s3_wr & (r_s3_ay.i0[0] == BSEL[1])
                              & (r_s3_ax.i0[0] == BSEL[0]);

        bmu_ram #(
            .WIDTH (VAL_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (bank_addr[b]),
            .i_wdata (r_s3_val),
            .i_raddr (bank_addr[b]),
            .o_rdata (bank_rdata[b])
        );
    end

    t_bank_sel         r_s4_sel;
    logic [FRAC_W-1:0] r_s4_fx, r_s4_fy;

    always_ff @(posedge i_clk) begin
        r_s4_sel.x0_odd <= r_s3_ax.i0[0];
        r_s4_sel.x1_odd <= r_s3_ax.i1[0];
        r_s4_sel.y0_odd <= r_s3_ay.i0[0];
        r_s4_sel.y1_odd <= r_s3_ay.i1[0];
        r_s4_fx         <= r_s3_ax.f;
        r_s4_fy         <= r_s3_ay.f;
    end

    // ------------------------------------------------------------------
    // Stage 5: horizontal blend of both rows
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]        m00, m01, m10, m11;
    logic signed [VAL_W+1:0] n_top, n_bot;
    logic [VAL_W-1:0]        r_s5_top, r_s5_bot;
    logic [FRAC_W-1:0]       r_s5_fy;

    assign m00 = bank_rdata[{r_s4_sel.y0_odd, r_s4_sel.x0_odd}];
    assign m01 = bank_rdata[{r_s4_sel.y0_odd, r_s4_sel.x1_odd}];
    assign m10 = bank_rdata[{r_s4_sel.y1_odd, r_s4_sel.x0_odd}];
    assign m11 = bank_rdata[{r_s4_sel.y1_odd, r_s4_sel.x1_odd}];

    assign n_top = lerp((VAL_W+2)'(m00), (VAL_W+2)'(m01), r_s4_fx);
    assign n_bot = lerp((VAL_W+2)'(m10), (VAL_W+2)'(m11), r_s4_fx);

    // a blend of two in-range values stays between them
    always_ff @(posedge i_clk) begin
        r_s5_top <= n_top[VAL_W-1:0];
        r_s5_bot <= n_bot[VAL_W-1:0];
        r_s5_fy  <= r_s4_fy;
    end

    // ------------------------------------------------------------------
    // Stage 6: vertical blend, clamp, output register
    // ------------------------------------------------------------------
    logic signed [VAL_W+1:0] n_p;
    logic [VAL_W-1:0]        n_prob, r_prob;

    assign n_p = lerp((VAL_W+2)'(r_s5_top), (VAL_W+2)'(r_s5_bot), r_s5_fy);

    always_comb begin
        if (n_p < 0) begin
            n_prob = '0;
        end else if (n_p > (VAL_W+2)'(65535)) begin
            n_prob = '1;
        end else begin
            n_prob = n_p[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prob <= n_prob;
    end

    assign o_valid = r_s6_q;
    assign o_prob  = r_prob;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(bank_we))
        else $error("more than one map bank written in a cycle");

    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s3_q && r_s3_wr))
        else $error("query and write in the same stage");

    a_x_neighbours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_q && (r_s3_ax.i1 != r_s3_ax.i0) |-> r_s3_ax.i1 == r_s3_ax.i0 + 1'b1)
        else $error("column neighbours not adjacent");

    a_y_neighbours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_q && (r_s3_ay.i1 != r_s3_ay.i0) |-> r_s3_ay.i1 == r_s3_ay.i0 + 1'b1)
        else $error("row neighbours not adjacent");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_op == OP_QUERY), 6))
        else $error("result without a query transaction six cycles earlier");

endmodule

// ===== bench/tb_bilinear_map_upscaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_map_upscaler: self-checking bench for the bilinear map upscaler
// Loads map entries, sweeps pixel queries under several scale settings and
// compares every o_prob with a bit-exact fixed-point blend kept in the bench.
// ----------------------------------------------------------------------------
module tb_bilinear_map_upscaler;
    import bmu_pkg::*;

    localparam int PIPE_LAT    = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int MAP_CELLS   = MAP_SIDE * MAP_SIDE;
    localparam int COORD_SPAN  = 1 << COORD_W;
    localparam int FULL_SCALE  = MAP_SIDE * 65536;

    typedef struct {
        t_map_op            op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [VAL_W-1:0]   value;
    } t_map_txn;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic                 i_op       = 1'b0;
    logic [COORD_W-1:0]   i_col      = '0;
    logic [COORD_W-1:0]   i_row      = '0;
    logic [VAL_W-1:0]     i_value    = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = REG_SCALE_X;
    logic [SCALE_W-1:0]   i_cfg_data = '0;
    logic                 o_valid;
    logic [VAL_W-1:0]     o_prob;

    // Mirror of the block: map contents and scales as seen at the ports
    logic [VAL_W-1:0]   map_mirror [MAP_CELLS];
    logic [SCALE_W-1:0] scale_x_q = SCALE_RESET;
    logic [SCALE_W-1:0] scale_y_q = SCALE_RESET;
    logic [VAL_W-1:0]   prob_expected_q [$];

    // Stimulus side: pending transactions and what the generator has loaded
    t_map_txn           txn_q [$];
    bit                 gen_written [MAP_CELLS];
    logic [SCALE_W-1:0] gen_sx = SCALE_RESET;
    logic [SCALE_W-1:0] gen_sy = SCALE_RESET;
    bit                 no_idle = 1'b0;
    bit                 txn_taken = 1'b0;

    int unsigned n_pushed = 0;
    int unsigned n_accepted = 0;
    int unsigned n_loaded = 0;
    int unsigned n_queries = 0;
    int unsigned n_writes = 0;
    int unsigned n_dropped = 0;
    int unsigned n_settings = 0;
    int unsigned n_errors = 0;
    int unsigned stall_cycles = 0;

    bilinear_map_upscaler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_value    (i_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_prob     (o_prob)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pixel index to neighbour indexes and Q0.16 fraction along one axis
    function automatic void map_axis(input logic [COORD_W-1:0] c,
                                     input logic [SCALE_W-1:0] s,
                                     output int unsigned i0, output int unsigned i1,
                                     output logic [FRAC_W-1:0] f);
        logic [63:0] twice_ctr;
        logic [63:0] src;
        logic [63:0] ip;
        twice_ctr = (64'(c) * 2 + 1) * 64'(s);
        src = (twice_ctr >= 64'd65536) ? (twice_ctr - 64'd65536) >> 1 : 64'd0;
        ip = src >> FRAC_W;
        if (ip > 64'(MAP_SIDE - 1)) ip = 64'(MAP_SIDE - 1);
        i0 = 32'(ip);
        i1 = (ip + 1 > 64'(MAP_SIDE - 1)) ? 32'(MAP_SIDE - 1) : 32'(ip + 1);
        f = src[FRAC_W-1:0];
    endfunction

    // a + floor(f * (b - a) / 2^16)
    function automatic longint blend(input longint a, input longint b,
                                     input logic [FRAC_W-1:0] f);
        longint fw;
        fw = longint'(64'(f));
        return a + ((fw * (b - a)) >>> FRAC_W);
    endfunction

    function automatic logic [VAL_W-1:0] bilinear_prob(input logic [COORD_W-1:0] col,
                                                       input logic [COORD_W-1:0] row);
        int unsigned       x0, x1, y0, y1;
        logic [FRAC_W-1:0] fx, fy;
        longint            top, bot, p;
        map_axis(col, scale_x_q, x0, x1, fx);
        map_axis(row, scale_y_q, y0, y1, fy);
        top = blend(map_mirror[y0 * MAP_SIDE + x0], map_mirror[y0 * MAP_SIDE + x1], fx);
        bot = blend(map_mirror[y1 * MAP_SIDE + x0], map_mirror[y1 * MAP_SIDE + x1], fx);
        p = blend(top, bot, fy);
        if (p < 0) begin
            p = 0;
        end else if (p > 65535) begin
            p = 65535;
        end
        return VAL_W'(p);
    endfunction

    // Driver: present the next pending transaction, or idle now and then
    always @(negedge i_clk) begin
        t_map_txn txn;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || txn_taken) begin
            txn_taken = 1'b0;
            if (txn_q.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
                txn = txn_q.pop_front();
                start   <= 1'b1;
                i_op    <= txn.op;
                i_col   <= txn.col;
                i_row   <= txn.row;
                i_value <= txn.value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: mirror config writes, predict accepted queries, check results
    always @(posedge i_clk) begin
        bit               moved;
        logic [VAL_W-1:0] want;
        moved = 1'b0;
        if (!i_rst_n) begin
            scale_x_q = SCALE_RESET;
            scale_y_q = SCALE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCALE_X: scale_x_q = i_cfg_data;
                    REG_SCALE_Y: scale_y_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                moved = 1'b1;
                txn_taken = 1'b1;
                n_accepted++;
                if (i_op == OP_QUERY) begin
                    prob_expected_q.push_back(bilinear_prob(i_col, i_row));
                    n_queries++;
                end else if (i_col < MAP_SIDE && i_row < MAP_SIDE) begin
                    map_mirror[i_row * MAP_SIDE + i_col] = i_value;
                    n_writes++;
                end else begin
                    n_dropped++;
                end
            end
            if (o_valid) begin
                if (prob_expected_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: prob with nothing expected: expected none, actual %0d",
                             $time, o_prob);
                end else begin
                    moved = 1'b1;
                    want = prob_expected_q.pop_front();
                    if (o_prob !== want) begin
                        n_errors++;
                        $display("%0t: prob mismatch: expected %0d, actual %0d",
                                 $time, want, o_prob);
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, prob_expected_q.size());
                $display("** bilinear_map_upscaler: FAILED **");
                $finish;
            end
        end
    end

    task automatic put_txn(input t_map_op op, input int unsigned col, input int unsigned row,
                           input logic [VAL_W-1:0] value);
        t_map_txn txn;
        txn.op    = op;
        txn.col   = COORD_W'(col);
        txn.row   = COORD_W'(row);
        txn.value = value;
        txn_q.push_back(txn);
        n_pushed++;
        if (op == OP_QUERY) begin
            n_loaded++;
        end else if (col < MAP_SIDE && row < MAP_SIDE) begin
            gen_written[row * MAP_SIDE + col] = 1'b1;
            n_loaded++;
        end
    endtask

    function automatic logic [VAL_W-1:0] rand_prob();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) return '0;
        if (pick < 30) return '1;
        return VAL_W'($urandom);
    endfunction

    // Load any neighbour that was never written, then issue the query
    task automatic put_query(input int unsigned col, input int unsigned row);
        int unsigned       xs [2];
        int unsigned       ys [2];
        logic [FRAC_W-1:0] frac;
        map_axis(COORD_W'(col), gen_sx, xs[0], xs[1], frac);
        map_axis(COORD_W'(row), gen_sy, ys[0], ys[1], frac);
        foreach (ys[j]) begin
            foreach (xs[k]) begin
                if (!gen_written[ys[j] * MAP_SIDE + xs[k]])
                    put_txn(OP_WRITE, xs[k], ys[j], rand_prob());
            end
        end
        put_txn(OP_QUERY, col, row, VAL_W'($urandom));
    endtask

    // Hold the sender until every transaction is in and every result is out
    task automatic drain();
        do @(negedge i_clk);
        while (n_accepted != n_pushed || prob_expected_q.size() != 0);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    task automatic set_scales(input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SCALE_X;
        i_cfg_data <= sx;
        @(negedge i_clk);
        i_cfg_idx  <= REG_SCALE_Y;
        i_cfg_data <= sy;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        gen_sx = sx;
        gen_sy = sy;
        n_settings++;
    endtask

    task automatic pick_scale(output logic [SCALE_W-1:0] scale, output int unsigned extent);
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            extent = $urandom_range(4096, MAP_SIDE / 2);
            scale  = SCALE_W'(FULL_SCALE / extent);
        end else if (kind < 8) begin
            extent = COORD_SPAN;
            scale  = SCALE_W'($urandom_range(FULL_SCALE, 1));
        end else begin
            extent = COORD_SPAN;
            scale  = SCALE_W'($urandom);
        end
    endtask

    function automatic int unsigned rand_coord(input int unsigned extent);
        if ($urandom_range(9) == 0) return $urandom_range(COORD_SPAN - 1);
        return $urandom_range(extent - 1);
    endfunction

    // Mostly short raster runs of queries, with stray and off-map writes mixed in
    task automatic run_phase(input int unsigned quota, input bit pause_midway);
        logic [SCALE_W-1:0] sx, sy;
        int unsigned        w, h, target, col, row, sel;
        pick_scale(sx, w);
        pick_scale(sy, h);
        set_scales(sx, sy);
        target = n_loaded + quota;
        while (n_loaded < target) begin
            if (pause_midway && n_loaded + quota / 2 >= target) begin
                drain();
                pause_midway = 1'b0;
            end
            sel = $urandom_range(99);
            if (sel < 70) begin
                col = rand_coord(w);
                row = rand_coord(h);
                repeat ($urandom_range(8, 1)) begin
                    put_query(col, row);
                    col = (col + 1) % COORD_SPAN;
                end
            end else if (sel < 90) begin
                put_txn(OP_WRITE, $urandom_range(MAP_SIDE - 1), $urandom_range(MAP_SIDE - 1),
                        rand_prob());
            end else if (sel < 95) begin
                put_txn(OP_WRITE, $urandom_range(COORD_SPAN - 1, MAP_SIDE),
                        $urandom_range(COORD_SPAN - 1), VAL_W'($urandom));
            end else begin
                put_txn(OP_WRITE, $urandom_range(COORD_SPAN - 1),
                        $urandom_range(COORD_SPAN - 1, MAP_SIDE), VAL_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset scales: off-map writes, full-swing corners, far edge clamp
        put_txn(OP_WRITE, MAP_SIDE, 0, '1);
        put_txn(OP_WRITE, 0, MAP_SIDE, '1);
        put_txn(OP_WRITE, COORD_SPAN - 1, COORD_SPAN - 1, '1);
        put_txn(OP_WRITE, 0, 0, '1);
        put_txn(OP_WRITE, 1, 0, '0);
        put_txn(OP_WRITE, 0, 1, '0);
        put_txn(OP_WRITE, 1, 1, '1);
        put_query(0, 0);
        put_query(1, 1);
        put_query(COORD_SPAN - 1, COORD_SPAN - 1);

        // Zero scale on x, all-ones scale on y
        set_scales('0, '1);
        put_query(0, 0);
        put_query(COORD_SPAN - 1, 1);

        // Smallest and largest legal scales
        set_scales(SCALE_W'(1), SCALE_W'(FULL_SCALE));
        put_query(COORD_SPAN - 1, 0);
        put_query(0, 1);

        // Fractional positions, falling slope across the corner entries
        set_scales(SCALE_W'(32768), SCALE_W'(98304));
        put_query(1, 1);
        put_query(2, 3);

        for (int p = 0; p < 6; p++) begin
            no_idle = (p == 2);
            run_phase(90, p == 3);
        end
        no_idle = 1'b0;
        drain();

        $display("Covered %0d queries, %0d map writes and %0d off-map writes",
                 n_queries, n_writes, n_dropped);
        $display("across %0d scale settings; %0d mismatches", n_settings + 1, n_errors);
        if (n_errors == 0) begin
            $display("** bilinear_map_upscaler: PASSED **");
        end else begin
            $display("** bilinear_map_upscaler: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/bmu_pkg.sv
src/bmu_ram.sv
src/bilinear_map_upscaler.sv
bench/tb_bilinear_map_upscaler.sv
